/* rtl/tmhq_pkg.sv */
// Shared types, codes and constants of the timer min-heap queue.
package tmhq_pkg;

  localparam int HEAP_DEPTH_DEF = 32;
  localparam int MAX_RESULTS    = 32;
  localparam int NPOP_W         = $clog2(MAX_RESULTS + 1);
  localparam int TIME_W         = 32;
  localparam int TAG_W          = 16;
  localparam int WAIT_W         = 43;
  localparam int STATUS_W       = 2;

  localparam logic [9:0] MS_PER_S = 10'd1000;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ADDED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXPIRED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE    = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic              go;
    logic              empty;
    logic [TIME_W-1:0] deadline;
    logic [TIME_W-1:0] now;
  } wait_req_t;

endpackage

/* rtl/tmhq_wait_unit.sv */
// Two-stage computation of the wait in milliseconds from the heap top.
module tmhq_wait_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tmhq_pkg::wait_req_t               req,
  output logic                              done,
  output logic signed [tmhq_pkg::WAIT_W-1:0] wait_ms
);

  logic                          v1_r;
  logic                          empty1_r;
  logic                          due1_r;
  logic [tmhq_pkg::TIME_W-1:0]   diff1_r;
  logic                          done_r;
  logic [tmhq_pkg::WAIT_W-1:0]   wait_r;
  logic [tmhq_pkg::WAIT_W-1:0]   prod;
  logic [tmhq_pkg::WAIT_W-1:0]   wait_nxt;

  assign prod = tmhq_pkg::WAIT_W'(diff1_r) * tmhq_pkg::WAIT_W'(tmhq_pkg::MS_PER_S);

  always_comb begin
    if (empty1_r) begin
      wait_nxt = '1;
    end else if (due1_r) begin
      wait_nxt = '0;
    end else begin
      wait_nxt = prod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= req.go;
      done_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      empty1_r <= req.empty;
      due1_r   <= (req.deadline <= req.now);
      diff1_r  <= req.deadline - req.now;
    end
    if (v1_r) begin
      wait_r <= wait_nxt;
    end
  end

  assign done    = done_r;
  assign wait_ms = signed'(wait_r);

endmodule

/* rtl/timer_min_heap_queue_core.sv */
// Timer queue top level: heap memory, sift sequencer and result emission.
//
//   channel  | ports                                    | transfer
//   ---------+------------------------------------------+---------------------------
//   input    | start, busy, in_op/now_time/delay/tag    | start && !busy at clk edge
//   result   | out_valid, out_status/expired_*/wait/last| out_valid, one cycle each
//
// Add: the new timer climbs, reading and comparing each parent, to the root or to a
// parent not later. Check: per popped timer the top and tail are read, then the hole
// sinks past each earlier child to a leaf; then the top not due is found (skipped when
// empty or at the cap). The wait and the results follow, paced by the one read port.
// Reset (rst_n low, synchronous) empties the heap at once; no clearing pass. Results
// cannot be stalled; the block raises busy for the whole item.
module timer_min_heap_queue_core #(
  parameter int HEAP_DEPTH = tmhq_pkg::HEAP_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_op,
  input  logic [tmhq_pkg::TIME_W-1:0]         in_now_time,
  input  logic [tmhq_pkg::TIME_W-1:0]         in_delay,
  input  logic [tmhq_pkg::TAG_W-1:0]          in_tag,
  output logic                                out_valid,
  output logic [tmhq_pkg::STATUS_W-1:0]       out_status,
  output logic [tmhq_pkg::TAG_W-1:0]          out_expired_tag,
  output logic [tmhq_pkg::TIME_W-1:0]         out_expired_deadline,
  output logic signed [tmhq_pkg::WAIT_W-1:0]  out_wait_ms,
  output logic                                out_last
);

  localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
  localparam int IDX_W = $clog2(HEAP_DEPTH);
  localparam int CH_W  = IDX_W + 2;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_UP_RD    = 4'd1;
  localparam logic [3:0] S_UP_CMP   = 4'd2;
  localparam logic [3:0] S_CHK_RD   = 4'd3;
  localparam logic [3:0] S_CHK_TOP  = 4'd4;
  localparam logic [3:0] S_CHK_LAST = 4'd5;
  localparam logic [3:0] S_DN_L     = 4'd6;
  localparam logic [3:0] S_DN_R     = 4'd7;
  localparam logic [3:0] S_DN_CMP   = 4'd8;
  localparam logic [3:0] S_WT_RD    = 4'd9;
  localparam logic [3:0] S_WT_GO    = 4'd10;
  localparam logic [3:0] S_WT_WAIT  = 4'd11;
  localparam logic [3:0] S_OUT_ONE  = 4'd12;
  localparam logic [3:0] S_OUT_RD   = 4'd13;
  localparam logic [3:0] S_OUT_SH   = 4'd14;

  tmhq_pkg::entry_t mem [HEAP_DEPTH];
  tmhq_pkg::entry_t rdata_r;
  logic [IDX_W-1:0] rd_addr;
  logic             we;
  logic [IDX_W-1:0] wr_addr;
  tmhq_pkg::entry_t wdata;

  logic [3:0]                    state_r, state_nxt;
  logic                          op_r, op_nxt;
  logic [tmhq_pkg::TIME_W-1:0]   now_r, now_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [IDX_W-1:0]              idx_r, idx_nxt;
  tmhq_pkg::entry_t              x_r, x_nxt;
  tmhq_pkg::entry_t              lc_r, lc_nxt;
  tmhq_pkg::entry_t              top_r, top_nxt;
  logic                          hasr_r, hasr_nxt;
  logic [tmhq_pkg::NPOP_W-1:0]   npop_r, npop_nxt;
  logic [IDX_W-1:0]              eidx_r, eidx_nxt;
  logic [tmhq_pkg::NPOP_W-1:0]   eleft_r, eleft_nxt;
  logic [tmhq_pkg::STATUS_W-1:0] st_r, st_nxt;

  logic                          ov_r, ov_nxt;
  logic [tmhq_pkg::STATUS_W-1:0] ostat_r, ostat_nxt;
  logic [tmhq_pkg::TAG_W-1:0]    otag_r, otag_nxt;
  logic [tmhq_pkg::TIME_W-1:0]   odl_r, odl_nxt;
  logic                          olast_r, olast_nxt;

  logic [tmhq_pkg::TIME_W:0]     sum;
  logic [tmhq_pkg::TIME_W-1:0]   new_dl;
  logic [IDX_W-1:0]              parent;
  logic [CH_W-1:0]               lch;
  logic [CH_W-1:0]               rch;
  logic [CH_W-1:0]               count_ext;
  logic [IDX_W-1:0]              last_idx;
  logic [CNT_W:0]                ebase;
  logic                          l_less;
  logic                          r_less;
  tmhq_pkg::entry_t              best;

  tmhq_pkg::wait_req_t           wreq;
  logic                          wdone;
  logic signed [tmhq_pkg::WAIT_W-1:0] wait_ms;

  tmhq_wait_unit u_wait (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (wreq),
    .done    (wdone),
    .wait_ms (wait_ms)
  );

  assign sum       = {1'b0, in_now_time} + {1'b0, in_delay};
  assign new_dl    = sum[tmhq_pkg::TIME_W] ? '1 : sum[tmhq_pkg::TIME_W-1:0];
  assign parent    = (idx_r - IDX_W'(1)) >> 1;
  assign lch       = {1'b0, idx_r, 1'b1};
  assign rch       = lch + CH_W'(1);
  assign count_ext = CH_W'(count_r);
  assign last_idx  = IDX_W'(count_r - CNT_W'(1));
  assign ebase     = (CNT_W + 1)'(count_r) + (CNT_W + 1)'(npop_r) - (CNT_W + 1)'(1);
  assign l_less    = lc_r.deadline < x_r.deadline;
  assign best      = l_less ? lc_r : x_r;
  assign r_less    = hasr_r && (rdata_r.deadline < best.deadline);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    now_nxt   = now_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    x_nxt     = x_r;
    lc_nxt    = lc_r;
    top_nxt   = top_r;
    hasr_nxt  = hasr_r;
    npop_nxt  = npop_r;
    eidx_nxt  = eidx_r;
    eleft_nxt = eleft_r;
    st_nxt    = st_r;
    ov_nxt    = 1'b0;
    ostat_nxt = ostat_r;
    otag_nxt  = otag_r;
    odl_nxt   = odl_r;
    olast_nxt = olast_r;
    rd_addr   = '0;
    we        = 1'b0;
    wr_addr   = idx_r;
    wdata     = x_r;
    wreq      = '{go: 1'b0, empty: (count_r == '0), deadline: rdata_r.deadline, now: now_r};

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt   = in_op;
          now_nxt  = in_now_time;
          npop_nxt = '0;
          if (in_op == tmhq_pkg::OP_CHECK) begin
            st_nxt    = tmhq_pkg::ST_NONE;
            state_nxt = S_CHK_RD;
          end else if (count_r >= CNT_W'(HEAP_DEPTH)) begin
            st_nxt    = tmhq_pkg::ST_FULL;
            state_nxt = S_WT_RD;
          end else begin
            st_nxt    = tmhq_pkg::ST_ADDED;
            x_nxt     = '{deadline: new_dl, tag: in_tag};
            idx_nxt   = count_r[IDX_W-1:0];
            count_nxt = count_r + CNT_W'(1);
            state_nxt = S_UP_RD;
          end
        end
      end
      S_UP_RD: begin
        if (idx_r == '0) begin
          we        = 1'b1;
          state_nxt = S_WT_RD;
        end else begin
          rd_addr   = parent;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (rdata_r.deadline > x_r.deadline) begin
          // move the parent down into the hole and climb
          wdata     = rdata_r;
          idx_nxt   = parent;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_WT_RD;
        end
      end
      S_CHK_RD: begin
        if ((count_r == '0) || (npop_r == tmhq_pkg::NPOP_W'(tmhq_pkg::MAX_RESULTS))) begin
          state_nxt = S_WT_RD;
        end else begin
          state_nxt = S_CHK_TOP;
        end
      end
      S_CHK_TOP: begin
        if (rdata_r.deadline > now_r) begin
          state_nxt = S_WT_RD;
        end else begin
          top_nxt   = rdata_r;
          rd_addr   = last_idx;
          state_nxt = S_CHK_LAST;
        end
      end
      S_CHK_LAST: begin
        // park the popped timer in the slot freed at the tail
        we        = 1'b1;
        wr_addr   = last_idx;
        wdata     = top_r;
        x_nxt     = rdata_r;
        count_nxt = count_r - CNT_W'(1);
        npop_nxt  = npop_r + tmhq_pkg::NPOP_W'(1);
        idx_nxt   = '0;
        state_nxt = (count_r == CNT_W'(1)) ? S_CHK_RD : S_DN_L;
      end
      S_DN_L: begin
        if (lch >= count_ext) begin
          we        = 1'b1;
          state_nxt = S_CHK_RD;
        end else begin
          rd_addr   = lch[IDX_W-1:0];
          state_nxt = S_DN_R;
        end
      end
      S_DN_R: begin
        lc_nxt = rdata_r;
        if (rch < count_ext) begin
          rd_addr  = rch[IDX_W-1:0];
          hasr_nxt = 1'b1;
        end else begin
          hasr_nxt = 1'b0;
        end
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (r_less) begin
          wdata     = rdata_r;
          idx_nxt   = rch[IDX_W-1:0];
          state_nxt = S_DN_L;
        end else if (l_less) begin
          wdata     = lc_r;
          idx_nxt   = lch[IDX_W-1:0];
          state_nxt = S_DN_L;
        end else begin
          state_nxt = S_CHK_RD;
        end
      end
      S_WT_RD: begin
        state_nxt = S_WT_GO;
      end
      S_WT_GO: begin
        wreq.go   = 1'b1;
        state_nxt = S_WT_WAIT;
      end
      S_WT_WAIT: begin
        if (wdone) begin
          if ((op_r == tmhq_pkg::OP_ADD) || (npop_r == '0)) begin
            state_nxt = S_OUT_ONE;
          end else begin
            eidx_nxt  = ebase[IDX_W-1:0];
            eleft_nxt = npop_r;
            state_nxt = S_OUT_RD;
          end
        end
      end
      S_OUT_ONE: begin
        ov_nxt    = 1'b1;
        ostat_nxt = st_r;
        otag_nxt  = '0;
        odl_nxt   = '0;
        olast_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_OUT_RD: begin
        rd_addr   = eidx_r;
        state_nxt = S_OUT_SH;
      end
      S_OUT_SH: begin
        ov_nxt    = 1'b1;
        ostat_nxt = tmhq_pkg::ST_EXPIRED;
        otag_nxt  = rdata_r.tag;
        odl_nxt   = rdata_r.deadline;
        olast_nxt = (eleft_r == tmhq_pkg::NPOP_W'(1));
        eleft_nxt = eleft_r - tmhq_pkg::NPOP_W'(1);
        eidx_nxt  = eidx_r - IDX_W'(1);
        state_nxt = (eleft_r == tmhq_pkg::NPOP_W'(1)) ? S_IDLE : S_OUT_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wdata;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      npop_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      npop_r  <= npop_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    now_r   <= now_nxt;
    idx_r   <= idx_nxt;
    x_r     <= x_nxt;
    lc_r    <= lc_nxt;
    top_r   <= top_nxt;
    hasr_r  <= hasr_nxt;
    eidx_r  <= eidx_nxt;
    eleft_r <= eleft_nxt;
    st_r    <= st_nxt;
    ostat_r <= ostat_nxt;
    otag_r  <= otag_nxt;
    odl_r   <= odl_nxt;
    olast_r <= olast_nxt;
  end

  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = ov_r;
  assign out_status           = ostat_r;
  assign out_expired_tag      = otag_r;
  assign out_expired_deadline = odl_r;
  assign out_wait_ms          = wait_ms;
  assign out_last             = olast_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(HEAP_DEPTH))
    else $error("heap count above depth");

  a_pop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    npop_r <= tmhq_pkg::NPOP_W'(tmhq_pkg::MAX_RESULTS))
    else $error("popped more timers than one check may return");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without work in progress");

  a_expired_due: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == tmhq_pkg::ST_EXPIRED)) |-> (out_expired_deadline <= now_r))
    else $error("expired timer deadline after check time");

endmodule

/* sim/tb_timer_min_heap_queue_core.sv */
// Testbench for the timer min-heap queue: random and directed requests checked against a heap predictor.

typedef struct {
  logic [tmhq_pkg::STATUS_W-1:0] status;
  logic [tmhq_pkg::TAG_W-1:0]    tag;
  logic [tmhq_pkg::TIME_W-1:0]   deadline;
  logic [tmhq_pkg::WAIT_W-1:0]   wait_ms;
  logic                          last;
} timer_result_t;

class timer_heap_scoreboard;
  tmhq_pkg::entry_t heap [tmhq_pkg::HEAP_DEPTH_DEF];
  int               heap_size;
  timer_result_t    expected_results[$];
  int               errors;

  function new();
    heap_size = 0;
    errors = 0;
  endfunction

  function logic [tmhq_pkg::WAIT_W-1:0] wait_ms_at(logic [tmhq_pkg::TIME_W-1:0] now_sec);
    logic [tmhq_pkg::TIME_W-1:0] remaining;
    logic [63:0]                 ms;
    if (heap_size == 0) return '1;
    if (heap[0].deadline <= now_sec) return '0;
    remaining = heap[0].deadline - now_sec;
    ms = 64'(remaining) * 64'(tmhq_pkg::MS_PER_S);
    return ms[tmhq_pkg::WAIT_W-1:0];
  endfunction

  function void sift_toward_root(int idx);
    int               parent;
    tmhq_pkg::entry_t held;
    while (idx > 0) begin
      parent = (idx - 1) / 2;
      // move only past a strictly later parent
      if (heap[parent].deadline <= heap[idx].deadline) break;
      held = heap[parent];
      heap[parent] = heap[idx];
      heap[idx] = held;
      idx = parent;
    end
  endfunction

  function void remove_earliest();
    int               idx;
    int               lchild;
    int               rchild;
    int               pick;
    tmhq_pkg::entry_t held;
    idx = 0;
    heap[0] = heap[heap_size - 1];
    heap_size--;
    forever begin
      lchild = 2 * idx + 1;
      rchild = 2 * idx + 2;
      pick = idx;
      if (lchild < heap_size && heap[lchild].deadline < heap[pick].deadline) pick = lchild;
      if (rchild < heap_size && heap[rchild].deadline < heap[pick].deadline) pick = rchild;
      if (pick == idx) break;
      held = heap[pick];
      heap[pick] = heap[idx];
      heap[idx] = held;
      idx = pick;
    end
  endfunction

  function void note_request(logic op, logic [tmhq_pkg::TIME_W-1:0] now_sec,
                             logic [tmhq_pkg::TIME_W-1:0] delay_sec,
                             logic [tmhq_pkg::TAG_W-1:0] tag_id);
    timer_result_t                res;
    tmhq_pkg::entry_t             popped[$];
    logic [tmhq_pkg::TIME_W:0]    sum;
    logic [tmhq_pkg::WAIT_W-1:0]  wait_now;
    res = '{default: '0};
    if (op == tmhq_pkg::OP_ADD) begin
      if (heap_size >= tmhq_pkg::HEAP_DEPTH_DEF) begin
        res.status = tmhq_pkg::ST_FULL;
      end else begin
        sum = {1'b0, now_sec} + {1'b0, delay_sec};
        // saturate the deadline at the top of the time range
        heap[heap_size].deadline = sum[tmhq_pkg::TIME_W] ? '1 : sum[tmhq_pkg::TIME_W-1:0];
        heap[heap_size].tag = tag_id;
        heap_size++;
        sift_toward_root(heap_size - 1);
        res.status = tmhq_pkg::ST_ADDED;
      end
      res.wait_ms = wait_ms_at(now_sec);
      res.last = 1'b1;
      expected_results.push_back(res);
      return;
    end
    while (popped.size() < tmhq_pkg::MAX_RESULTS && heap_size > 0
           && heap[0].deadline <= now_sec) begin
      popped.push_back(heap[0]);
      remove_earliest();
    end
    wait_now = wait_ms_at(now_sec);
    if (popped.size() == 0) begin
      res.status = tmhq_pkg::ST_NONE;
      res.wait_ms = wait_now;
      res.last = 1'b1;
      expected_results.push_back(res);
      return;
    end
    foreach (popped[k]) begin
      res.status = tmhq_pkg::ST_EXPIRED;
      res.tag = popped[k].tag;
      res.deadline = popped[k].deadline;
      res.wait_ms = wait_now;
      res.last = (k == popped.size() - 1);
      expected_results.push_back(res);
    end
  endfunction

  function void check_result(logic [tmhq_pkg::STATUS_W-1:0] status,
                             logic [tmhq_pkg::TAG_W-1:0] tag_id,
                             logic [tmhq_pkg::TIME_W-1:0] deadline,
                             logic [tmhq_pkg::WAIT_W-1:0] wait_ms, logic last);
    timer_result_t want;
    if (expected_results.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: status %0d tag %h deadline %h wait_ms %0d last %b",
                 status, tag_id, deadline, $signed(wait_ms), last);
      return;
    end
    want = expected_results.pop_front();
    if (want.status !== status || want.tag !== tag_id || want.deadline !== deadline
        || want.wait_ms !== wait_ms || want.last !== last) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch: expected status %0d tag %h deadline %h wait_ms %0d last %b",
                 want.status, want.tag, want.deadline, $signed(want.wait_ms), want.last);
        $display("          got      status %0d tag %h deadline %h wait_ms %0d last %b",
                 status, tag_id, deadline, $signed(wait_ms), last);
      end
    end
  endfunction
endclass

module tb_timer_min_heap_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic                                clk = 1'b0;
  logic                                rst_n;
  logic                                start;
  logic                                busy;
  logic                                in_op;
  logic [tmhq_pkg::TIME_W-1:0]         in_now_time;
  logic [tmhq_pkg::TIME_W-1:0]         in_delay;
  logic [tmhq_pkg::TAG_W-1:0]          in_tag;
  logic                                out_valid;
  logic [tmhq_pkg::STATUS_W-1:0]       out_status;
  logic [tmhq_pkg::TAG_W-1:0]          out_expired_tag;
  logic [tmhq_pkg::TIME_W-1:0]         out_expired_deadline;
  logic signed [tmhq_pkg::WAIT_W-1:0]  out_wait_ms;
  logic                                out_last;

  timer_heap_scoreboard sb = new();
  bit                   steady = 1'b0;

  timer_min_heap_queue_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_op                (in_op),
    .in_now_time          (in_now_time),
    .in_delay             (in_delay),
    .in_tag               (in_tag),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_expired_tag      (out_expired_tag),
    .out_expired_deadline (out_expired_deadline),
    .out_wait_ms          (out_wait_ms),
    .out_last             (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result(out_status, out_expired_tag, out_expired_deadline, out_wait_ms, out_last);
  end

  task automatic send_request(input logic op, input logic [tmhq_pkg::TIME_W-1:0] now_sec,
                              input logic [tmhq_pkg::TIME_W-1:0] delay_sec,
                              input logic [tmhq_pkg::TAG_W-1:0] tag_id);
    int gap;
    if (!steady && $urandom_range(99) < 22) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(5, 25) : $urandom_range(1, 3);
      start <= 1'b0;
      // scramble the fields while start is low; the block must ignore them
      repeat (gap) begin
        in_op <= 1'($urandom);
        in_now_time <= $urandom;
        in_delay <= $urandom;
        in_tag <= 16'($urandom);
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_op <= op;
    in_now_time <= now_sec;
    in_delay <= delay_sec;
    in_tag <= tag_id;
    do @(posedge clk); while (busy);
    sb.note_request(op, now_sec, delay_sec, tag_id);
  endtask

  task automatic drain_results(input int extra);
    start <= 1'b0;
    do @(posedge clk); while (sb.expected_results.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  initial begin
    #50_000_000;
    $display("tb_timer_min_heap_queue_core NOT OK");
    $finish;
  end

  initial begin
    logic [tmhq_pkg::TIME_W-1:0] base;
    logic [tmhq_pkg::TIME_W-1:0] now_sec;
    logic [tmhq_pkg::TIME_W-1:0] delay_sec;
    logic                        op;
    int                          pick;

    rst_n <= 1'b0;
    start <= 1'b0;
    in_op <= tmhq_pkg::OP_ADD;
    in_now_time <= '0;
    in_delay <= '0;
    in_tag <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_request(tmhq_pkg::OP_CHECK, 32'd0, 32'd0, 16'd0);
    send_request(tmhq_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(tmhq_pkg::OP_ADD, 32'd1000, 32'd0, 16'h0000);
    send_request(tmhq_pkg::OP_ADD, 32'd1000, 32'd5, 16'h0001);
    // equal deadlines keep their heap order
    send_request(tmhq_pkg::OP_ADD, 32'd1000, 32'd5, 16'h0002);
    send_request(tmhq_pkg::OP_ADD, 32'd1000, 32'd2, 16'h0003);
    send_request(tmhq_pkg::OP_CHECK, 32'd999, 32'd0, 16'd0);
    send_request(tmhq_pkg::OP_CHECK, 32'd1000, 32'd0, 16'd0);
    send_request(tmhq_pkg::OP_CHECK, 32'd1006, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(tmhq_pkg::OP_ADD, 32'd0, 32'hFFFF_FFFF, 16'hAAAA);
    send_request(tmhq_pkg::OP_CHECK, 32'hFFFF_FFFE, 32'd0, 16'd0);
    send_request(tmhq_pkg::OP_CHECK, 32'hFFFF_FFFF, 32'd0, 16'd0);
    send_request(tmhq_pkg::OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 16'h5555);
    send_request(tmhq_pkg::OP_CHECK, 32'd0, 32'd0, 16'd0);
    send_request(tmhq_pkg::OP_CHECK, 32'hFFFF_FFFF, 32'd0, 16'd0);
    drain_results(4);

    // fill the heap, overflow it, then expire everything in one check
    for (int k = 0; k < tmhq_pkg::HEAP_DEPTH_DEF + 2; k++)
      send_request(tmhq_pkg::OP_ADD, 32'd500, $urandom_range(0, 40), 16'($urandom));
    send_request(tmhq_pkg::OP_CHECK, 32'd400, 32'd0, 16'd0);
    send_request(tmhq_pkg::OP_CHECK, 32'hFFFF_FFFF, 32'd0, 16'd0);
    drain_results(4);

    base = $urandom_range(0, 1000);
    for (int i = 0; i < 380; i++) begin
      steady = (i >= 60 && i < 140);
      if ($urandom_range(99) < 3) base = $urandom;
      else base = base + $urandom_range(0, 6);
      now_sec = ($urandom_range(99) < 10) ? $urandom : base;
      pick = $urandom_range(99);
      if (pick < 70) delay_sec = $urandom_range(0, 30);
      else if (pick < 85) delay_sec = $urandom;
      else delay_sec = 32'hFFFF_FFFF - $urandom_range(0, 5);
      // a burst of adds drives the heap to full again
      if (i >= 180 && i < 215) op = tmhq_pkg::OP_ADD;
      else if (sb.heap_size >= tmhq_pkg::HEAP_DEPTH_DEF)
        op = ($urandom_range(99) < 25) ? tmhq_pkg::OP_ADD : tmhq_pkg::OP_CHECK;
      else op = ($urandom_range(99) < 55) ? tmhq_pkg::OP_ADD : tmhq_pkg::OP_CHECK;
      send_request(op, now_sec, delay_sec, 16'($urandom));
      if (i == 300) drain_results(4);
    end
    steady = 1'b0;
    drain_results(20);

    if (sb.errors == 0 && sb.expected_results.size() == 0)
      $display("tb_timer_min_heap_queue_core OK");
    else
      $display("tb_timer_min_heap_queue_core NOT OK");
    $finish;
  end
endmodule

/* sim.f */
rtl/tmhq_pkg.sv
rtl/tmhq_wait_unit.sv
rtl/timer_min_heap_queue_core.sv
sim/tb_timer_min_heap_queue_core.sv
